// ===== rtl/ecss_pkg.sv =====
// Shared types and constants for the entity and component store.
// Depends on nothing; ecss_ctrl, ecss_dp and the top file refer to it by scoped names.
`timescale 1ns / 1ps

package ecss_pkg;

  localparam int MAX_ENTITIES = 256;
  localparam int COMP_TYPES   = 8;
  localparam int HANDLE_BITS  = 32;

  localparam int EW = $clog2(MAX_ENTITIES);   // entity id / slot width
  localparam int TW = $clog2(COMP_TYPES);     // component type width
  localparam int CW = EW + 1;                 // counts that reach MAX_ENTITIES
  localparam int DW = TW + EW;                // per-type array address

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_ENTITY = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_PRESENT    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_C_COMMIT,
    S_L1,
    S_L2,
    S_A_COMMIT,
    S_D_SCAN,
    S_D_IDX,
    S_D_REL,
    S_D_MOVE,
    S_D_FIN,
    S_D_FIN2,
    S_REPORT
  } state_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_C_READ,
    A_C_COMMIT,
    A_L_READ0,
    A_L_READ1,
    A_ADD_COMMIT,
    A_D_START,
    A_D_NEXT,
    A_D_SCAN,
    A_D_IDX,
    A_D_REL,
    A_D_MOVE,
    A_D_FIN,
    A_D_COMMIT,
    A_REPORT
  } act_t;

  typedef struct packed {
    act_t    act;
    logic    set_code;
    status_t code;
  } cmd_t;

  typedef struct packed {
    op_t           op;
    logic          create_full;
    logic          bad_type;
    logic          dead;
    logic          dup;
    logic          add_full;
    logic          scan_bit;
    logic          t_last;
    logic          skip;
    logic          out_free;
    logic          any;
    logic [CW-1:0] live_cnt;
    logic [CW-1:0] free_cnt;
    logic [CW-1:0] next_fresh;
  } stat_t;

endpackage

// ===== rtl/ecss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read data holds while no read is enabled.
`timescale 1ns / 1ps

module ecss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ecss_ctrl.sv =====
// Sequencer for the entity and component store: one request at a time.
// Depends on ecss_pkg; drives commands to ecss_dp and reads its status.
`timescale 1ns / 1ps

module ecss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ecss_pkg::stat_t stat,
  output ecss_pkg::cmd_t  cmd
);

  ecss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.act      = ecss_pkg::A_NONE;
    cmd.set_code = 1'b0;
    cmd.code     = ecss_pkg::ST_OK;
    in_stall     = 1'b1;
    case (state)
      ecss_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.act    = ecss_pkg::A_LOAD;
          state_next = ecss_pkg::S_DISPATCH;
        end
      end
      ecss_pkg::S_DISPATCH: begin
        case (stat.op)
          ecss_pkg::OP_CREATE: begin
            if (stat.create_full) begin
              cmd.set_code = 1'b1;
              cmd.code     = ecss_pkg::ST_FULL;
              state_next   = ecss_pkg::S_REPORT;
            end else begin
              cmd.act    = ecss_pkg::A_C_READ;
              state_next = ecss_pkg::S_C_COMMIT;
            end
          end
          ecss_pkg::OP_ADD: begin
            if (stat.bad_type) begin
              cmd.set_code = 1'b1;
              cmd.code     = ecss_pkg::ST_BAD_TYPE;
              state_next   = ecss_pkg::S_REPORT;
            end else begin
              cmd.act    = ecss_pkg::A_L_READ0;
              state_next = ecss_pkg::S_L1;
            end
          end
          ecss_pkg::OP_DELETE: begin
            cmd.act    = ecss_pkg::A_L_READ0;
            state_next = ecss_pkg::S_L1;
          end
          default: begin
            cmd.set_code = 1'b1;
            cmd.code     = ecss_pkg::ST_BAD_ENTITY;
            state_next   = ecss_pkg::S_REPORT;
          end
        endcase
      end
      ecss_pkg::S_C_COMMIT: begin
        if (stat.out_free) begin
          cmd.act    = ecss_pkg::A_C_COMMIT;
          state_next = ecss_pkg::S_IDLE;
        end
      end
      ecss_pkg::S_L1: begin
        cmd.act    = ecss_pkg::A_L_READ1;
        state_next = ecss_pkg::S_L2;
      end
      ecss_pkg::S_L2: begin
        if (stat.dead) begin
          cmd.set_code = 1'b1;
          cmd.code     = ecss_pkg::ST_BAD_ENTITY;
          state_next   = ecss_pkg::S_REPORT;
        end else if (stat.op == ecss_pkg::OP_ADD) begin
          if (stat.dup) begin
            cmd.set_code = 1'b1;
            cmd.code     = ecss_pkg::ST_PRESENT;
            state_next   = ecss_pkg::S_REPORT;
          end else if (stat.add_full) begin
            cmd.set_code = 1'b1;
            cmd.code     = ecss_pkg::ST_FULL;
            state_next   = ecss_pkg::S_REPORT;
          end else begin
            state_next = ecss_pkg::S_A_COMMIT;
          end
        end else begin
          cmd.act    = ecss_pkg::A_D_START;
          state_next = ecss_pkg::S_D_SCAN;
        end
      end
      ecss_pkg::S_A_COMMIT: begin
        if (stat.out_free) begin
          cmd.act    = ecss_pkg::A_ADD_COMMIT;
          state_next = ecss_pkg::S_IDLE;
        end
      end
      ecss_pkg::S_D_SCAN: begin
        if (stat.scan_bit) begin
          cmd.act    = ecss_pkg::A_D_SCAN;
          state_next = ecss_pkg::S_D_IDX;
        end else if (stat.t_last) begin
          state_next = ecss_pkg::S_D_FIN;
        end else begin
          cmd.act = ecss_pkg::A_D_NEXT;
        end
      end
      ecss_pkg::S_D_IDX: begin
        if (stat.skip) begin
          if (stat.t_last) begin
            state_next = ecss_pkg::S_D_FIN;
          end else begin
            cmd.act    = ecss_pkg::A_D_NEXT;
            state_next = ecss_pkg::S_D_SCAN;
          end
        end else begin
          cmd.act    = ecss_pkg::A_D_IDX;
          state_next = ecss_pkg::S_D_REL;
        end
      end
      ecss_pkg::S_D_REL: begin
        cmd.act    = ecss_pkg::A_D_REL;
        state_next = ecss_pkg::S_D_MOVE;
      end
      ecss_pkg::S_D_MOVE: begin
        if (stat.out_free) begin
          cmd.act    = ecss_pkg::A_D_MOVE;
          state_next = stat.t_last ? ecss_pkg::S_D_FIN : ecss_pkg::S_D_SCAN;
        end
      end
      ecss_pkg::S_D_FIN: begin
        cmd.act    = ecss_pkg::A_D_FIN;
        state_next = ecss_pkg::S_D_FIN2;
      end
      ecss_pkg::S_D_FIN2: begin
        if (stat.any || stat.out_free) begin
          cmd.act    = ecss_pkg::A_D_COMMIT;
          state_next = ecss_pkg::S_IDLE;
        end
      end
      ecss_pkg::S_REPORT: begin
        if (stat.out_free) begin
          cmd.act    = ecss_pkg::A_REPORT;
          state_next = ecss_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ecss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ecss_dp.sv =====
// Datapath of the entity and component store: tables, counters, output register.
// Depends on ecss_pkg and ecss_ram; acts on commands from ecss_ctrl.
`timescale 1ns / 1ps

module ecss_dp #(
  parameter int HANDLE_BITS = ecss_pkg::HANDLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   op,
  input  logic [ecss_pkg::EW-1:0]      entity,
  input  logic [ecss_pkg::TW-1:0]      comp_type,
  input  logic [HANDLE_BITS-1:0]       handle,
  input  ecss_pkg::cmd_t               cmd,
  output ecss_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [ecss_pkg::EW-1:0]      result_entity,
  output logic                         released_valid,
  output logic [ecss_pkg::TW-1:0]      released_type,
  output logic [HANDLE_BITS-1:0]       released_handle,
  output logic                         last
);

  localparam int EW = ecss_pkg::EW;
  localparam int TW = ecss_pkg::TW;
  localparam int CW = ecss_pkg::CW;
  localparam int DW = ecss_pkg::DW;
  localparam int NT = ecss_pkg::COMP_TYPES;
  localparam int NE = ecss_pkg::MAX_ENTITIES;

  // request
  ecss_pkg::op_t          op_r;
  logic [EW-1:0]          e_r;
  logic [TW-1:0]          t_r;
  logic [HANDLE_BITS-1:0] h_r;

  // control state
  logic [CW-1:0] next_fresh, live_cnt, free_cnt;
  logic [CW-1:0] fill [NT];
  logic [TW-1:0] t2;
  logic          any_r;

  // working registers
  logic [EW-1:0]          slot_r, idx_r, mover_r;
  logic [NT-1:0]          mask_r;
  logic [HANDLE_BITS-1:0] rel_r;
  ecss_pkg::status_t      code_r;
  logic [EW-1:0]          rent_r;

  // memory ports
  logic                   free_we, free_re;
  logic [EW-1:0]          free_wa, free_ra, free_wd, free_rd;
  logic                   act_we, act_re;
  logic [EW-1:0]          act_wa, act_ra, act_wd, act_rd;
  logic                   slot_we, slot_re;
  logic [EW-1:0]          slot_wa, slot_ra, slot_wd, slot_rd;
  logic                   mask_we, mask_re;
  logic [EW-1:0]          mask_wa, mask_ra;
  logic [NT-1:0]          mask_wd, mask_rd;
  logic                   sp_we, sp_re;
  logic [DW-1:0]          sp_wa, sp_ra;
  logic [EW-1:0]          sp_wd, sp_rd;
  logic                   pay_we, pay_re;
  logic [DW-1:0]          pay_wa, pay_ra;
  logic [HANDLE_BITS-1:0] pay_wd, pay_rd;
  logic                   own_we, own_re;
  logic [DW-1:0]          own_wa, own_ra;
  logic [EW-1:0]          own_wd, own_rd;

  logic [CW-1:0] fill_t2, fill_t;
  logic [EW-1:0] lastd, create_id;
  logic [NT-1:0] hi_mask;
  logic          out_free, emit;
  ecss_pkg::status_t      e_status;
  logic [EW-1:0]          e_entity;
  logic                   e_rv, e_last;
  logic [TW-1:0]          e_type;
  logic [HANDLE_BITS-1:0] e_handle;

  assign fill_t2   = fill[t2];
  assign fill_t    = fill[t_r];
  assign lastd     = EW'(fill_t2 - CW'(1));
  assign create_id = (free_cnt != '0) ? free_rd : next_fresh[EW-1:0];
  assign out_free  = !out_valid || !out_stall;
  // types above the current one still to be released
  assign hi_mask   = ~((NT'(2) << t2) - NT'(1));

  always_comb begin
    stat.op          = op_r;
    stat.create_full = (free_cnt == '0) && (next_fresh == CW'(NE));
    stat.bad_type    = {1'b0, t_r} >= (TW + 1)'(NT);
    // ids never issued are dead whatever their unwritten table entries hold
    stat.dead        = ({1'b0, e_r} >= next_fresh) || ({1'b0, slot_r} >= live_cnt) ||
                       (act_rd != e_r);
    stat.dup         = mask_r[t_r];
    stat.add_full    = fill_t >= CW'(NE);
    stat.scan_bit    = mask_r[t2];
    stat.t_last      = t2 == TW'(NT - 1);
    stat.skip        = (fill_t2 == '0) || ({1'b0, sp_rd} >= fill_t2);
    stat.out_free    = out_free;
    stat.any         = any_r;
    stat.live_cnt    = live_cnt;
    stat.free_cnt    = free_cnt;
    stat.next_fresh  = next_fresh;
  end

  // memory commands
  always_comb begin
    free_we = 1'b0; free_wa = free_cnt[EW-1:0]; free_wd = e_r;
    free_re = 1'b0; free_ra = EW'(free_cnt - CW'(1));
    act_we  = 1'b0; act_wa = live_cnt[EW-1:0]; act_wd = create_id;
    act_re  = 1'b0; act_ra = slot_rd;
    slot_we = 1'b0; slot_wa = create_id; slot_wd = live_cnt[EW-1:0];
    slot_re = 1'b0; slot_ra = e_r;
    mask_we = 1'b0; mask_wa = e_r; mask_wd = '0;
    mask_re = 1'b0; mask_ra = e_r;
    sp_we   = 1'b0; sp_wa = {t_r, e_r}; sp_wd = fill_t[EW-1:0];
    sp_re   = 1'b0; sp_ra = {t2, e_r};
    pay_we  = 1'b0; pay_wa = {t_r, fill_t[EW-1:0]}; pay_wd = h_r;
    pay_re  = 1'b0; pay_ra = {t2, sp_rd};
    own_we  = 1'b0; own_wa = {t_r, fill_t[EW-1:0]}; own_wd = e_r;
    own_re  = 1'b0; own_ra = {t2, lastd};
    case (cmd.act)
      ecss_pkg::A_C_READ: begin
        free_re = free_cnt != '0;
      end
      ecss_pkg::A_C_COMMIT: begin
        mask_we = 1'b1;
        mask_wa = create_id;
        act_we  = 1'b1;
        slot_we = 1'b1;
      end
      ecss_pkg::A_L_READ0: begin
        slot_re = 1'b1;
        mask_re = 1'b1;
      end
      ecss_pkg::A_L_READ1: begin
        act_re = 1'b1;
      end
      ecss_pkg::A_ADD_COMMIT: begin
        sp_we   = 1'b1;
        pay_we  = 1'b1;
        own_we  = 1'b1;
        mask_we = 1'b1;
        mask_wd = mask_r | (NT'(1) << t_r);
      end
      ecss_pkg::A_D_SCAN: begin
        sp_re = 1'b1;
      end
      ecss_pkg::A_D_IDX: begin
        pay_re = 1'b1;
        own_re = 1'b1;
      end
      ecss_pkg::A_D_REL: begin
        pay_re = 1'b1;
        pay_ra = {t2, lastd};
      end
      ecss_pkg::A_D_MOVE: begin
        // move the last dense entry into the hole
        if (idx_r != lastd) begin
          pay_we = 1'b1;
          pay_wa = {t2, idx_r};
          pay_wd = pay_rd;
          own_we = 1'b1;
          own_wa = {t2, idx_r};
          own_wd = mover_r;
          sp_we  = 1'b1;
          sp_wa  = {t2, mover_r};
          sp_wd  = idx_r;
        end
      end
      ecss_pkg::A_D_FIN: begin
        mask_we = 1'b1;
        act_re  = 1'b1;
        act_ra  = EW'(live_cnt - CW'(1));
      end
      ecss_pkg::A_D_COMMIT: begin
        act_we  = 1'b1;
        act_wa  = slot_r;
        act_wd  = act_rd;
        slot_we = 1'b1;
        slot_wa = act_rd;
        slot_wd = slot_r;
        free_we = free_cnt < CW'(NE);
      end
      default: begin
      end
    endcase
  end

  // result selection
  always_comb begin
    emit     = 1'b0;
    e_status = ecss_pkg::ST_OK;
    e_entity = e_r;
    e_rv     = 1'b0;
    e_type   = '0;
    e_handle = '0;
    e_last   = 1'b1;
    case (cmd.act)
      ecss_pkg::A_C_COMMIT: begin
        emit     = 1'b1;
        e_entity = create_id;
      end
      ecss_pkg::A_ADD_COMMIT: begin
        emit = 1'b1;
      end
      ecss_pkg::A_D_MOVE: begin
        emit     = 1'b1;
        e_rv     = 1'b1;
        e_type   = t2;
        e_handle = rel_r;
        e_last   = ~|(mask_r & hi_mask);
      end
      ecss_pkg::A_D_COMMIT: begin
        emit = !any_r;
      end
      ecss_pkg::A_REPORT: begin
        emit     = 1'b1;
        e_status = code_r;
        e_entity = rent_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_fresh <= '0;
      live_cnt   <= '0;
      free_cnt   <= '0;
      any_r      <= 1'b0;
      t2         <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.act)
        ecss_pkg::A_C_COMMIT: begin
          live_cnt <= live_cnt + CW'(1);
          if (free_cnt != '0) begin
            free_cnt <= free_cnt - CW'(1);
          end else begin
            next_fresh <= next_fresh + CW'(1);
          end
        end
        ecss_pkg::A_ADD_COMMIT: begin
          fill[t_r] <= fill_t + CW'(1);
        end
        ecss_pkg::A_D_START: begin
          t2    <= '0;
          any_r <= 1'b0;
        end
        ecss_pkg::A_D_NEXT: begin
          t2 <= t2 + TW'(1);
        end
        ecss_pkg::A_D_MOVE: begin
          fill[t2] <= fill_t2 - CW'(1);
          any_r    <= 1'b1;
          t2       <= t2 + TW'(1);
        end
        ecss_pkg::A_D_COMMIT: begin
          live_cnt <= live_cnt - CW'(1);
          if (free_cnt < CW'(NE)) begin
            free_cnt <= free_cnt + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ecss_pkg::A_LOAD) begin
      op_r <= ecss_pkg::op_t'(op);
      e_r  <= entity;
      t_r  <= comp_type;
      h_r  <= handle;
    end
    if (cmd.act == ecss_pkg::A_L_READ1) begin
      slot_r <= slot_rd;
      mask_r <= mask_rd;
    end
    if (cmd.act == ecss_pkg::A_D_IDX) begin
      idx_r <= sp_rd;
    end
    if (cmd.act == ecss_pkg::A_D_REL) begin
      rel_r   <= pay_rd;
      mover_r <= own_rd;
    end
    if (cmd.set_code) begin
      code_r <= cmd.code;
      rent_r <= (op_r == ecss_pkg::OP_CREATE) ? '0 : e_r;
    end
    if (emit) begin
      status          <= e_status;
      result_entity   <= e_entity;
      released_valid  <= e_rv;
      released_type   <= e_type;
      released_handle <= e_handle;
      last            <= e_last;
    end
  end

  ecss_ram #(.WIDTH(EW), .DEPTH(NE)) u_free (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
    .re(free_re), .raddr(free_ra), .rdata(free_rd)
  );

  ecss_ram #(.WIDTH(EW), .DEPTH(NE)) u_active (
    .clk(clk), .we(act_we), .waddr(act_wa), .wdata(act_wd),
    .re(act_re), .raddr(act_ra), .rdata(act_rd)
  );

  ecss_ram #(.WIDTH(EW), .DEPTH(NE)) u_slot_of (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
    .re(slot_re), .raddr(slot_ra), .rdata(slot_rd)
  );

  ecss_ram #(.WIDTH(NT), .DEPTH(NE)) u_mask (
    .clk(clk), .we(mask_we), .waddr(mask_wa), .wdata(mask_wd),
    .re(mask_re), .raddr(mask_ra), .rdata(mask_rd)
  );

  ecss_ram #(.WIDTH(EW), .DEPTH(NT * NE)) u_sparse (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd),
    .re(sp_re), .raddr(sp_ra), .rdata(sp_rd)
  );

  ecss_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NT * NE)) u_payload (
    .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(pay_wd),
    .re(pay_re), .raddr(pay_ra), .rdata(pay_rd)
  );

  ecss_ram #(.WIDTH(EW), .DEPTH(NT * NE)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
    .re(own_re), .raddr(own_ra), .rdata(own_rd)
  );

endmodule

// ===== rtl/entity_component_sparse_set_unit.sv =====
// Entity and component store: free-list id allocator, packed active list, and one
// sparse set per component type. The input stalls while a request runs; how long
// create, add, errors and delete take is set by the single read port of each table
// RAM and the dependent reads, delete walking every component type, and grows while
// a stalled result holds a commit back. One request at a time.
// Synchronous reset clears counters and sequencer; ids never issued read as dead.
`timescale 1ns / 1ps

module entity_component_sparse_set_unit #(
  parameter int HANDLE_BITS = ecss_pkg::HANDLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [ecss_pkg::EW-1:0]      entity,
  input  logic [ecss_pkg::TW-1:0]      comp_type,
  input  logic [HANDLE_BITS-1:0]       handle,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [ecss_pkg::EW-1:0]      result_entity,
  output logic                         released_valid,
  output logic [ecss_pkg::TW-1:0]      released_type,
  output logic [HANDLE_BITS-1:0]       released_handle,
  output logic                         last
);

  ecss_pkg::cmd_t  cmd;
  ecss_pkg::stat_t stat;

  // Sequencer: accepts one request, walks the table reads and writes it needs.
  ecss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, counters and the output register.
  ecss_dp #(.HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .entity          (entity),
    .comp_type       (comp_type),
    .handle          (handle),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .result_entity   (result_entity),
    .released_valid  (released_valid),
    .released_type   (released_type),
    .released_handle (released_handle),
    .last            (last)
  );

  // Every id ever handed out is either live or waiting on the free list.
  a_id_balance: assert property (@(posedge clk) disable iff (rst)
    (stat.live_cnt + stat.free_cnt) == stat.next_fresh)
    else $error("live and free counts do not add up to issued ids");

  // The live list never grows past the store size.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    stat.live_cnt <= ecss_pkg::CW'(ecss_pkg::MAX_ENTITIES))
    else $error("live count exceeds store size");

  // Only component releases of a delete may leave the request open.
  a_open_is_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> released_valid)
    else $error("non-final result that reports no release");

  // Release fields read zero when nothing is released.
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !released_valid) |-> (released_type == '0 && released_handle == '0))
    else $error("release fields set without a release");

endmodule
